[rtl/textured_wall_column_shader_macros.svh]
// Assertion macros shared by the shader RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef TEXTURED_WALL_COLUMN_SHADER_MACROS_SVH
`define TEXTURED_WALL_COLUMN_SHADER_MACROS_SVH
`ifndef SYNTHESIS
`define TWS_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define TWS_NEVER(lbl, ck, rn, expr, msg) \
  `TWS_ASSERT(lbl, ck, rn, !(expr), msg)
`else
`define TWS_ASSERT(lbl, ck, rn, prop, msg)
`define TWS_NEVER(lbl, ck, rn, expr, msg)
`endif
`endif

[rtl/tws_pkg.sv]
// Shared constants, types and the cosine table for the wall column shader.
// No dependencies.
package tws_pkg;

  localparam int TILE        = 64;
  localparam int TEX_WIDTH   = 64;
  localparam int TEX_HEIGHT  = 64;
  localparam int TEX_COUNT   = 8;
  localparam int STORE_DEPTH = 32768;
  localparam int STORE_AW    = 15;
  localparam int QUARTER     = 1024;
  localparam int COS_W       = 15;

  localparam logic [9:0]  SCREEN_HEIGHT_RST = 10'd480;
  localparam logic [15:0] PLANE_DIST_RST    = 16'd554;
  localparam logic [31:0] CEIL_COLOR_RST    = 32'hFF33_3333;
  localparam logic [31:0] FLOOR_COLOR_RST   = 32'hFF77_7777;

  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd0;
  localparam logic [1:0] CFG_PLANE_DIST    = 2'd1;
  localparam logic [1:0] CFG_CEIL_COLOR    = 2'd2;
  localparam logic [1:0] CFG_FLOOR_COLOR   = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  typedef enum logic [1:0] {
    REG_CEIL  = 2'd0,
    REG_WALL  = 2'd1,
    REG_FLOOR = 2'd2
  } region_t;

  typedef logic [COS_W-1:0] cos_tab_t [0:QUARTER];

  // Quarter-wave cosine, Q1.14, via a nine-term Taylor series in Q30
  function automatic cos_tab_t build_cos();
    cos_tab_t t;
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint sum;
    for (int k = 0; k <= QUARTER; k++) begin
      theta = (64'(k) * 64'd6746518852) >> 12;
      x2 = (theta * theta) >> 30;
      term = 64'd1 << 30;
      sum = 64'sd1 <<< 30;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (unsigned'(sum) + 64'd32768) >> 16;
      if (q > 64'd16384) begin
        q = 64'd16384;
      end
      t[k] = q[COS_W-1:0];
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos();

endpackage

[rtl/tws_channels.sv]
// Valid/ready channel interfaces for shader items and shaded pixels.
// No dependencies; the region field is a plain two-bit vector.
interface tws_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [14:0] texel_index;
  logic [31:0] texel_value;
  logic [9:0]  column;
  logic [9:0]  row;
  logic [23:0] ray_distance;
  logic [11:0] angle_offset;
  logic [15:0] hit_x;
  logic [15:0] hit_y;
  logic        hit_vertical;
  logic [3:0]  wall_kind;

  modport source (output valid, opcode, texel_index, texel_value, column, row,
                  ray_distance, angle_offset, hit_x, hit_y, hit_vertical, wall_kind,
                  input ready);
  modport sink (input valid, opcode, texel_index, texel_value, column, row,
                ray_distance, angle_offset, hit_x, hit_y, hit_vertical, wall_kind,
                output ready);
endinterface

interface tws_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_column;
  logic [9:0]  out_row;
  logic [31:0] pixel_color;
  logic [1:0]  region;

  modport source (output valid, out_column, out_row, pixel_color, region, input ready);
  modport sink (input valid, out_column, out_row, pixel_color, region, output ready);
endinterface

[rtl/tws_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module tws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/textured_wall_column_shader.sv]
// Textured wall column shader: one pipelined item per clock, in order, while the
// skid entry is empty. The strip height comes from a restoring divider that
// settles one quotient bit per pipeline stage, the texture row from a second
// one, and both loads and texel lookups go to the single port of the
// 32768-word texture store at the same stage, so they keep their order without
// forwarding. Texels are not cleared at reset and must be loaded before use.
// A two-entry output buffer (output register and skid entry) lets a finished
// pixel wait without blocking intake; intake stalls while the skid entry is full.
// Depends on tws_pkg, tws_channels, tws_ram and the assertion macro header.
`include "textured_wall_column_shader_macros.svh"

module textured_wall_column_shader #(
  parameter int TILE       = tws_pkg::TILE,
  parameter int TEX_WIDTH  = tws_pkg::TEX_WIDTH,
  parameter int TEX_HEIGHT = tws_pkg::TEX_HEIGHT,
  parameter int TEX_COUNT  = tws_pkg::TEX_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  tws_in_if.sink      in_ch,
  tws_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW     = tws_pkg::STORE_AW;
  localparam int P_W    = 24 + tws_pkg::COS_W;
  localparam int DW     = P_W + 16;
  localparam int TH_W   = $clog2(TEX_HEIGHT + 1);
  localparam int N2W    = 16 + TH_W;
  localparam int TRQ_W  = $clog2(TEX_HEIGHT);
  localparam int TC_W   = $clog2(TEX_WIDTH);
  localparam int TX_W   = (TEX_COUNT > 1) ? $clog2(TEX_COUNT) : 1;
  localparam int ST_D1  = 4;
  localparam int ST_H   = ST_D1 + 16;
  localparam int ST_D2  = ST_H + 1;
  localparam int ST_F   = ST_D2 + TRQ_W;
  localparam int NST    = ST_F + 1;
  localparam logic [32:0] TILE_RECIP = 33'((64'd1 << 32) / TILE);

  typedef struct packed {
    logic                vld;
    logic                op;
    logic [14:0]         idx;
    logic [31:0]         val;
    logic [9:0]          col;
    logic [9:0]          row;
    logic [23:0]         rdist;
    logic [11:0]         ang;
    logic [15:0]         sel;
    logic [3:0]          kind;
    logic [15:0]         qest;
    logic [14:0]         cval;
    logic                cpos;
    logic [P_W-1:0]      p;
    logic [TC_W-1:0]     tc;
    logic [TX_W-1:0]     tex;
    logic                ovf;
    logic [DW-1:0]       rem1;
    logic [15:0]         quo1;
    logic [15:0]         height;
    tws_pkg::region_t    region;
    logic [N2W-1:0]      rem2;
    logic [TRQ_W-1:0]    quo2;
  } item_t;

  typedef struct packed {
    logic [9:0]       col;
    logic [9:0]       row;
    logic [31:0]      color;
    tws_pkg::region_t region;
  } res_t;

  // Configuration registers
  logic [9:0]  sh_r;
  logic [15:0] plane_r;
  logic [31:0] ceil_r;
  logic [31:0] floor_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r    <= tws_pkg::SCREEN_HEIGHT_RST;
      plane_r <= tws_pkg::PLANE_DIST_RST;
      ceil_r  <= tws_pkg::CEIL_COLOR_RST;
      floor_r <= tws_pkg::FLOOR_COLOR_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        tws_pkg::CFG_SCREEN_HEIGHT: sh_r <= pwdata[9:0];
        tws_pkg::CFG_PLANE_DIST:    plane_r <= pwdata[15:0];
        tws_pkg::CFG_CEIL_COLOR:    ceil_r <= pwdata;
        tws_pkg::CFG_FLOOR_COLOR:   floor_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tws_pkg::CFG_SCREEN_HEIGHT: prdata = {22'd0, sh_r};
      tws_pkg::CFG_PLANE_DIST:    prdata = {16'd0, plane_r};
      tws_pkg::CFG_CEIL_COLOR:    prdata = ceil_r;
      tws_pkg::CFG_FLOOR_COLOR:   prdata = floor_r;
      default:                    prdata = 32'd0;
    endcase
  end

  // Pipeline
  item_t st_r   [0:NST-1];
  item_t st_nxt [0:NST-1];
  logic  pipe_en;
  logic  skid_valid_r;

  assign pipe_en     = !skid_valid_r;
  assign in_ch.ready = pipe_en;

  logic [1:0]          c_quad;
  logic [10:0]         c_idx;
  logic                c_neg;
  logic [14:0]         c_val;
  logic [48:0]         q_prod;
  logic [15:0]         tc_mul;
  logic [15:0]         tc_rem;
  logic [DW-1:0]       num;
  logic [15:0]         h_val;
  logic [8:0]          half;
  logic [14:0]         hh;
  logic [15:0]         top;
  logic [15:0]         bottom;
  logic [15:0]         diff;
  logic [4:0]          tex_k;
  logic [TRQ_W:0]      tr;
  logic [31:0]         addr_full;
  logic [AW-1:0]       ram_addr;
  logic                ram_we;
  logic [31:0]         ram_rdata;

  always_comb begin
    for (int k = 1; k < NST; k++) begin
      st_nxt[k] = st_r[k-1];
    end

    // Capture the accepted transaction
    st_nxt[0]       = st_r[0];
    st_nxt[0].vld   = in_ch.valid;
    st_nxt[0].op    = in_ch.opcode;
    st_nxt[0].idx   = in_ch.texel_index;
    st_nxt[0].val   = in_ch.texel_value;
    st_nxt[0].col   = in_ch.column;
    st_nxt[0].row   = in_ch.row;
    st_nxt[0].rdist = in_ch.ray_distance;
    st_nxt[0].ang   = in_ch.angle_offset;
    st_nxt[0].sel   = in_ch.hit_vertical ? in_ch.hit_y : in_ch.hit_x;
    st_nxt[0].kind  = in_ch.wall_kind;

    // Cosine lookup and reciprocal estimate of hit / TILE
    c_quad = st_r[0].ang[11:10];
    c_idx  = (c_quad == 2'd1 || c_quad == 2'd3) ?
             11'(11'd1024 - {1'b0, st_r[0].ang[9:0]}) : {1'b0, st_r[0].ang[9:0]};
    c_neg  = (c_quad == 2'd1 || c_quad == 2'd2);
    c_val  = tws_pkg::COS_TAB[c_idx];
    q_prod = 49'(st_r[0].sel) * 49'(TILE_RECIP);
    st_nxt[1].cval = c_val;
    st_nxt[1].cpos = !c_neg && (c_val != '0) && (st_r[0].rdist != '0);
    st_nxt[1].qest = q_prod[47:32];

    // Perpendicular distance and texture column
    st_nxt[2].p = P_W'(st_r[1].rdist) * P_W'(st_r[1].cval);
    tc_mul = 16'(32'(st_r[1].qest) * 32'(TILE));
    tc_rem = st_r[1].sel - tc_mul;
    if (tc_rem >= 16'(TILE)) begin
      tc_rem = tc_rem - 16'(TILE);
    end
    if (tc_rem >= 16'(TEX_WIDTH)) begin
      tc_rem = 16'(TEX_WIDTH - 1);
    end
    st_nxt[2].tc = tc_rem[TC_W-1:0];

    // Saturation check before the height divider
    num = DW'((64'(TILE) * 64'(plane_r)) << 22);
    st_nxt[3].rem1 = num;
    st_nxt[3].quo1 = '0;
    st_nxt[3].ovf  = num >= (DW'(st_r[2].p) << 16);

    // Height divider: one quotient bit per stage
    for (int j = 0; j < 16; j++) begin
      if (st_r[ST_D1+j-1].rem1 >= (DW'(st_r[ST_D1+j-1].p) << (15 - j))) begin
        st_nxt[ST_D1+j].rem1 = st_r[ST_D1+j-1].rem1 - (DW'(st_r[ST_D1+j-1].p) << (15 - j));
        st_nxt[ST_D1+j].quo1[15-j] = 1'b1;
      end
    end

    // Strip edges, region and texture row numerator
    h_val  = !st_r[ST_H-1].cpos ? 16'd0 :
             st_r[ST_H-1].ovf ? 16'hFFFF : st_r[ST_H-1].quo1;
    half   = sh_r[9:1];
    hh     = h_val[15:1];
    top    = ({1'b0, hh} >= 16'(half)) ? 16'd0 : 16'(half) - {1'b0, hh};
    bottom = 16'(half) + {1'b0, hh};
    if (bottom > 16'(sh_r)) begin
      bottom = 16'(sh_r);
    end
    diff   = 16'(st_r[ST_H-1].row) + {1'b0, hh} - 16'(half);
    tex_k  = (st_r[ST_H-1].kind == 4'd0) ? 5'd0 : 5'(st_r[ST_H-1].kind - 4'd1);
    if (tex_k >= 5'(TEX_COUNT)) begin
      tex_k = 5'(TEX_COUNT - 1);
    end
    st_nxt[ST_H].height = h_val;
    st_nxt[ST_H].tex    = TX_W'(tex_k);
    st_nxt[ST_H].rem2   = N2W'(32'(diff) * 32'(TEX_HEIGHT));
    st_nxt[ST_H].quo2   = '0;
    if (16'(st_r[ST_H-1].row) < top) begin
      st_nxt[ST_H].region = tws_pkg::REG_CEIL;
    end else if (16'(st_r[ST_H-1].row) < bottom && h_val != 16'd0) begin
      st_nxt[ST_H].region = tws_pkg::REG_WALL;
    end else begin
      st_nxt[ST_H].region = tws_pkg::REG_FLOOR;
    end

    // Texture row divider
    for (int j = 0; j < TRQ_W; j++) begin
      if (st_r[ST_D2+j-1].rem2 >=
          (N2W'(st_r[ST_D2+j-1].height) << (TRQ_W - 1 - j))) begin
        st_nxt[ST_D2+j].rem2 = st_r[ST_D2+j-1].rem2 -
                               (N2W'(st_r[ST_D2+j-1].height) << (TRQ_W - 1 - j));
        st_nxt[ST_D2+j].quo2[TRQ_W-1-j] = 1'b1;
      end
    end
  end

  // Texel address for the store access issued into the final stage
  always_comb begin
    tr = {1'b0, st_r[ST_F-1].quo2};
    if (32'(tr) >= 32'(TEX_HEIGHT)) begin
      tr = (TRQ_W+1)'(TEX_HEIGHT - 1);
    end
    addr_full = 32'(st_r[ST_F-1].tex) * 32'(TEX_WIDTH * TEX_HEIGHT) +
                32'(tr) * 32'(TEX_WIDTH) + 32'(st_r[ST_F-1].tc);
    ram_addr  = (st_r[ST_F-1].op == tws_pkg::OP_LOAD) ? st_r[ST_F-1].idx : addr_full[AW-1:0];
    ram_we    = st_r[ST_F-1].vld && (st_r[ST_F-1].op == tws_pkg::OP_LOAD);
  end

  tws_ram #(
    .WIDTH (32),
    .DEPTH (tws_pkg::STORE_DEPTH)
  ) u_tex_store (
    .clk   (clk),
    .en    (pipe_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (st_r[ST_F-1].val),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        st_r[k].vld <= 1'b0;
      end
    end else if (pipe_en) begin
      st_r <= st_nxt;
    end
  end

  // Output register and skid entry
  res_t f_res;
  res_t out_r;
  res_t skid_r;
  logic out_valid_r;
  logic f_res_vld;
  logic out_take;

  assign f_res_vld = st_r[ST_F].vld && (st_r[ST_F].op == tws_pkg::OP_SHADE);
  assign out_take  = out_valid_r && out_ch.ready;

  always_comb begin
    f_res.col    = st_r[ST_F].col;
    f_res.row    = st_r[ST_F].row;
    f_res.region = st_r[ST_F].region;
    case (st_r[ST_F].region)
      tws_pkg::REG_CEIL: f_res.color = ceil_r;
      tws_pkg::REG_WALL: f_res.color = ram_rdata;
      default:           f_res.color = floor_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pipe_en && f_res_vld) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
        out_r       <= f_res;
      end else begin
        skid_valid_r <= 1'b1;
        skid_r       <= f_res;
      end
    end else if (out_take) begin
      // Drain the skid entry, else empty the output
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_column  = out_r.col;
  assign out_ch.out_row     = out_r.row;
  assign out_ch.pixel_color = out_r.color;
  assign out_ch.region      = out_r.region;

  `TWS_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r, "skid full, output empty")
  `TWS_NEVER(a_wall_height, clk, rst_n, st_r[ST_F].vld && st_r[ST_F].op == tws_pkg::OP_SHADE && st_r[ST_F].region == tws_pkg::REG_WALL && st_r[ST_F].height == 16'd0, "wall pixel with zero height")
  `TWS_ASSERT(a_stall_holds, clk, rst_n, !pipe_en |=> $stable(st_r[ST_F]), "final stage moved during stall")
  `TWS_NEVER(a_ceil_zero_height, clk, rst_n, st_r[ST_H].vld && !st_r[ST_H].cpos && st_r[ST_H].height != 16'd0, "height set for non-positive distance")

endmodule
